// File: rtl/tvwm_pkg.sv
// Shared constants, widths and the CORDIC angle table for the tilt and vibration block.
package tvwm_pkg;

  // Window geometry (the length must be a power of two)
  localparam int WIN_LEN = 32;
  localparam int WIN_AW  = $clog2(WIN_LEN);

  // Datapath widths
  localparam int AXIS_W = 16;
  localparam int SUM_W  = AXIS_W + WIN_AW;
  localparam int DEV_W  = SUM_W + 1;
  localparam int SQ_W   = 2 * DEV_W;
  localparam int DACC_W = SQ_W + 2;
  localparam int SUMD_W = DACC_W + WIN_AW;
  localparam int SSQ_W  = 2 * SUM_W;
  localparam int RAD_W  = SSQ_W + 2;
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 1;
  localparam int CIN_W  = ROOT_W + 1;
  localparam int CW     = CIN_W + 13;
  localparam int ZW     = 27;
  localparam int CNT_W  = 5;
  localparam int ATAN_W = 22;
  localparam int ANG_W  = 19;
  localparam int VIB_W  = 17;
  localparam int KW     = 17;
  localparam int COV_W  = 32;
  localparam int P1_W   = COV_W + 1;
  localparam int DEN_W  = COV_W + 2;
  localparam int DREM_W = COV_W + 3;

  // Configuration port
  localparam int CFG_DW = 24;
  localparam int CFG_AW = 1;
  localparam logic [CFG_AW-1:0] CFG_KQ = 1'b0;
  localparam logic [CFG_AW-1:0] CFG_KR = 1'b1;
  localparam logic [CFG_DW-1:0] KQ_RESET = 24'd5243;
  localparam logic [CFG_DW-1:0] KR_RESET = 24'd22938;

  // Algorithm constants
  localparam int CORDIC_STEPS = 23;
  localparam int CORDIC_PRE   = 8;
  localparam int ANGLE_LIMIT  = 184320;
  localparam int VIB_LIMIT    = 131071;
  localparam int P_START      = 655360;
  localparam int Z180         = 180 * 65536;
  localparam int KONE         = 65536;

  // atan(2^-i) in degrees, scaled by 65536
  function automatic logic [ATAN_W-1:0] atan_tab(input logic [CNT_W-1:0] i);
    logic [ATAN_W-1:0] v;
    case (i)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      5'd20:   v = 22'd4;
      5'd21:   v = 22'd2;
      5'd22:   v = 22'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/tilt_vibration_window_metrics.sv
// Tilt and vibration metrics over a window of three-axis acceleration samples.
// Throughput: samples 1 to 31 of a window are taken one per cycle; busy stays low.
// The closing sample holds busy high while the block runs a squarer pass over every sample,
// the square roots, per angle the CORDIC (bypassed when y is zero) and the
// gain divider (not used on the first window); valid_o then pulses once.
// Reset (async, active low) clears the sequencer, fill count, filter start flag and configuration registers.
module tilt_vibration_window_metrics
  import tvwm_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_AW-1:0]        cfg_idx_i,
  input  logic [CFG_DW-1:0]        cfg_data_i,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [AXIS_W-1:0] accel_x_i,
  input  logic signed [AXIS_W-1:0] accel_y_i,
  input  logic signed [AXIS_W-1:0] accel_z_i,
  output logic                     valid_o,
  output logic signed [ANG_W-1:0]  tilt_pitch_o,
  output logic signed [ANG_W-1:0]  tilt_roll_o,
  output logic signed [ANG_W-1:0]  tilt_total_o,
  output logic [VIB_W-1:0]         vibration_rms_o,
  output logic [VIB_W-1:0]         vibration_peak_o
);

  // Sequencer codes
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_VRD  = 4'd1;
  localparam logic [3:0] ST_VSQ  = 4'd2;
  localparam logic [3:0] ST_VACC = 4'd3;
  localparam logic [3:0] ST_SSQ  = 4'd4;
  localparam logic [3:0] ST_QI   = 4'd5;
  localparam logic [3:0] ST_QR   = 4'd6;
  localparam logic [3:0] ST_CI   = 4'd7;
  localparam logic [3:0] ST_CR   = 4'd8;
  localparam logic [3:0] ST_CF   = 4'd9;
  localparam logic [3:0] ST_KS   = 4'd10;
  localparam logic [3:0] ST_KD   = 4'd11;
  localparam logic [3:0] ST_KX   = 4'd12;
  localparam logic [3:0] ST_KP   = 4'd13;

  localparam logic [WIN_AW-1:0] LAST_IDX = WIN_AW'(WIN_LEN - 1);

  // Control registers
  logic [3:0]        state_q, state_d;
  logic [WIN_AW-1:0] fill_q;
  logic [WIN_AW-1:0] idx_q, idx_d;
  logic [2:0]        sel_q, sel_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              started_q, started_d;
  logic              valid_q, valid_d;
  logic [CFG_DW-1:0] kq_q, kr_q;

  // Datapath registers
  logic [3*AXIS_W-1:0]       win_mem [WIN_LEN];
  logic [3*AXIS_W-1:0]       rd_q;
  logic signed [SUM_W-1:0]   sum_q [3];
  logic [DACC_W-1:0]         dacc_q, maxd_q;
  logic [SUMD_W-1:0]         sumd_q;
  logic [SSQ_W-1:0]          ssq_q [3];
  logic [RAD_W-1:0]          op_q;
  logic [REM_W-1:0]          rem_q;
  logic [ROOT_W-1:0]         root_q;
  logic [ROOT_W-1:0]         mag_q [3];
  logic signed [CW-1:0]      cx_q, cy_q;
  logic signed [ZW-1:0]      cz_q;
  logic signed [ANG_W-1:0]   m_q;
  logic signed [ANG_W-1:0]   est_q [3];
  logic [COV_W-1:0]          cov_q [3];
  logic [P1_W-1:0]           p1_q;
  logic [DEN_W-1:0]          den_q;
  logic [DREM_W-1:0]         drem_q;
  logic [KW-1:0]             k_q;
  logic signed [ANG_W-1:0]   pitch_q, roll_q, total_q;
  logic [VIB_W-1:0]          rms_q, peak_q;

  logic in_go;
  logic signed [AXIS_W-1:0] smp [3];

  assign in_go  = start && !busy;
  assign smp[0] = accel_x_i;
  assign smp[1] = accel_y_i;
  assign smp[2] = accel_z_i;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kq_q <= KQ_RESET;
      kr_q <= KR_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_KQ) kq_q <= cfg_data_i;
      if (cfg_idx_i == CFG_KR) kr_q <= cfg_data_i;
    end
  end

  // Fill count, wraps at the window length
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (in_go) begin
      fill_q <= fill_q + 1'b1;
    end
  end

  // Window memory: written per transfer, read once per sample in the deviation pass
  always_ff @(posedge clk_i) begin
    if (in_go) win_mem[fill_q] <= {accel_x_i, accel_y_i, accel_z_i};
    if (state_q == ST_VRD) rd_q <= win_mem[idx_q];
  end

  // Running per-axis window sums
  always_ff @(posedge clk_i) begin
    if (in_go) begin
      for (int a = 0; a < 3; a++) begin
        sum_q[a] <= ((fill_q == '0) ? SUM_W'(0) : sum_q[a]) + SUM_W'(smp[a]);
      end
    end
  end

  // Shared squarer: deviation of a sample from the mean, or a window sum
  logic signed [AXIS_W-1:0] rd_smp;
  logic signed [SUM_W-1:0]  sum_sel;
  logic signed [DEV_W-1:0]  sq_op;
  logic [DEV_W-1:0]         sq_mag;
  logic [SQ_W-1:0]          sq_res;

  always_comb begin
    case (sel_q)
      3'd0:    begin rd_smp = $signed(rd_q[3*AXIS_W-1:2*AXIS_W]); sum_sel = sum_q[0]; end
      3'd1:    begin rd_smp = $signed(rd_q[2*AXIS_W-1:AXIS_W]);   sum_sel = sum_q[1]; end
      default: begin rd_smp = $signed(rd_q[AXIS_W-1:0]);          sum_sel = sum_q[2]; end
    endcase
    if (state_q == ST_VSQ) sq_op = (DEV_W'(rd_smp) <<< WIN_AW) - DEV_W'(sum_sel);
    else                   sq_op = DEV_W'(sum_sel);
    sq_mag = sq_op[DEV_W-1] ? DEV_W'(-sq_op) : DEV_W'(sq_op);
  end

  assign sq_res = sq_mag * sq_mag;

  // Bit-serial square root, one root bit per cycle
  logic [RAD_W-1:0]  rad_in;
  logic [REM_W+1:0]  q_cur;
  logic [REM_W+1:0]  q_trial;
  logic              q_ge;
  logic [ROOT_W-1:0] root_nx;

  always_comb begin
    case (sel_q)
      3'd0:    rad_in = RAD_W'(ssq_q[1]) + RAD_W'(ssq_q[2]);
      3'd1:    rad_in = RAD_W'(ssq_q[0]) + RAD_W'(ssq_q[2]);
      3'd2:    rad_in = RAD_W'(ssq_q[0]) + RAD_W'(ssq_q[1]);
      3'd3:    rad_in = RAD_W'(sumd_q >> (3 * WIN_AW));
      default: rad_in = RAD_W'(maxd_q >> (2 * WIN_AW));
    endcase
    q_cur   = {rem_q, op_q[RAD_W-1 -: 2]};
    q_trial = (REM_W + 2)'({root_q, 2'b01});
    q_ge    = q_cur >= q_trial;
    root_nx = {root_q[ROOT_W-2:0], q_ge};
  end

  // CORDIC operands and one vectoring step
  logic signed [CIN_W-1:0] cin_x, cin_y;
  logic signed [CW-1:0]    cxs, cys, c_dx, c_dy;
  logic signed [ZW-1:0]    c_at;
  logic signed [ZW-1:0]    z_rnd;
  logic signed [ANG_W-1:0] z_clamp;

  always_comb begin
    case (sel_q)
      3'd0:    begin cin_x = $signed({1'b0, mag_q[0]}); cin_y = CIN_W'(sum_q[0]); end
      3'd1:    begin cin_x = $signed({1'b0, mag_q[1]}); cin_y = CIN_W'(sum_q[1]); end
      default: begin cin_x = CIN_W'(sum_q[2]); cin_y = $signed({1'b0, mag_q[2]}); end
    endcase
    cxs   = CW'(cin_x) <<< CORDIC_PRE;
    cys   = CW'(cin_y) <<< CORDIC_PRE;
    c_dx  = cy_q >>> cnt_q;
    c_dy  = cx_q >>> cnt_q;
    c_at  = $signed(ZW'(atan_tab(cnt_q)));
    z_rnd = (cz_q + ZW'(32)) >>> 6;
    if (z_rnd > ZW'(ANGLE_LIMIT))       z_clamp = ANG_W'(ANGLE_LIMIT);
    else if (z_rnd < ZW'(-ANGLE_LIMIT)) z_clamp = ANG_W'(-ANGLE_LIMIT);
    else                                z_clamp = ANG_W'(z_rnd);
  end

  // Kalman gain divider and update arithmetic
  logic [P1_W-1:0]           p1_c;
  logic [DEN_W-1:0]          den_c;
  logic [DREM_W-1:0]         d_cur;
  logic                      d_ge;
  logic signed [ANG_W:0]     k_diff;
  logic signed [ANG_W+KW+1:0] k_prod;
  logic signed [ANG_W+3:0]   x_sum;
  logic signed [ANG_W-1:0]   x_new;
  logic [KW-1:0]             k_cmp;
  logic [KW+P1_W-1:0]        p_prod;
  logic [KW+P1_W-17:0]       p_rnd;
  logic [COV_W-1:0]          p_new;

  always_comb begin
    p1_c   = P1_W'(cov_q[sel_q[1:0]]) + P1_W'(kq_q);
    den_c  = DEN_W'(p1_c) + DEN_W'(kr_q);
    d_cur  = (cnt_q == '0) ? drem_q : {drem_q[DREM_W-2:0], 1'b0};
    d_ge   = d_cur >= DREM_W'(den_q);
    k_diff = (ANG_W + 1)'(m_q) - (ANG_W + 1)'(est_q[sel_q[1:0]]);
    k_prod = $signed({1'b0, k_q}) * k_diff;
    x_sum  = (ANG_W + 4)'(est_q[sel_q[1:0]])
           + (ANG_W + 4)'((k_prod + (ANG_W + KW + 2)'(32768)) >>> 16);
    if (x_sum > (ANG_W + 4)'(ANGLE_LIMIT))       x_new = ANG_W'(ANGLE_LIMIT);
    else if (x_sum < (ANG_W + 4)'(-ANGLE_LIMIT)) x_new = ANG_W'(-ANGLE_LIMIT);
    else                                         x_new = ANG_W'(x_sum);
    k_cmp  = KW'(KONE) - k_q;
    p_prod = k_cmp * p1_q;
    p_rnd  = (KW + P1_W - 16)'((p_prod + (KW + P1_W)'(32768)) >> 16);
    p_new  = (|p_rnd[KW+P1_W-17:COV_W]) ? '1 : p_rnd[COV_W-1:0];
  end

  // Sequencer next state
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    sel_d     = sel_q;
    cnt_d     = cnt_q;
    started_d = started_q;
    valid_d   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_go && fill_q == LAST_IDX) begin
          state_d = ST_VRD;
          idx_d   = '0;
        end
      end
      ST_VRD: begin
        state_d = ST_VSQ;
        sel_d   = '0;
      end
      ST_VSQ: begin
        if (sel_q == 3'd2) state_d = ST_VACC;
        else               sel_d   = sel_q + 1'b1;
      end
      ST_VACC: begin
        if (idx_q == LAST_IDX) begin
          state_d = ST_SSQ;
          sel_d   = '0;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_VRD;
        end
      end
      ST_SSQ: begin
        if (sel_q == 3'd2) begin
          state_d = ST_QI;
          sel_d   = '0;
        end else begin
          sel_d = sel_q + 1'b1;
        end
      end
      ST_QI: begin
        state_d = ST_QR;
        cnt_d   = '0;
      end
      ST_QR: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(ROOT_W - 1)) begin
          if (sel_q == 3'd4) begin
            sel_d   = '0;
            state_d = ST_CI;
          end else begin
            sel_d   = sel_q + 1'b1;
            state_d = ST_QI;
          end
        end
      end
      ST_CI: begin
        cnt_d   = '0;
        state_d = (cin_y == '0) ? ST_KS : ST_CR;
      end
      ST_CR: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(CORDIC_STEPS - 1)) state_d = ST_CF;
      end
      ST_CF: state_d = ST_KS;
      ST_KS: begin
        cnt_d = '0;
        if (!started_q) begin
          if (sel_q == 3'd2) begin
            state_d   = ST_IDLE;
            started_d = 1'b1;
            valid_d   = 1'b1;
          end else begin
            sel_d   = sel_q + 1'b1;
            state_d = ST_CI;
          end
        end else if (den_c == '0) begin
          state_d = ST_KX;
        end else begin
          state_d = ST_KD;
        end
      end
      ST_KD: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(KW - 1)) state_d = ST_KX;
      end
      ST_KX: state_d = ST_KP;
      ST_KP: begin
        if (sel_q == 3'd2) begin
          state_d   = ST_IDLE;
          started_d = 1'b1;
          valid_d   = 1'b1;
        end else begin
          sel_d   = sel_q + 1'b1;
          state_d = ST_CI;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      sel_q     <= '0;
      cnt_q     <= '0;
      started_q <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      sel_q     <= sel_d;
      cnt_q     <= cnt_d;
      started_q <= started_d;
      valid_q   <= valid_d;
    end
  end

  // Datapath updates per sequencer step
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_go && fill_q == LAST_IDX) begin
          sumd_q <= '0;
          maxd_q <= '0;
        end
      end
      ST_VSQ: dacc_q <= ((sel_q == 3'd0) ? DACC_W'(0) : dacc_q) + DACC_W'(sq_res);
      ST_VACC: begin
        sumd_q <= sumd_q + SUMD_W'(dacc_q);
        if (dacc_q > maxd_q) maxd_q <= dacc_q;
      end
      ST_SSQ: ssq_q[sel_q[1:0]] <= sq_res[SSQ_W-1:0];
      ST_QI: begin
        op_q   <= rad_in;
        rem_q  <= '0;
        root_q <= '0;
      end
      ST_QR: begin
        op_q   <= op_q << 2;
        rem_q  <= q_ge ? REM_W'(q_cur - q_trial) : REM_W'(q_cur);
        root_q <= root_nx;
        if (cnt_q == CNT_W'(ROOT_W - 1)) begin
          case (sel_q)
            3'd0, 3'd1, 3'd2: mag_q[sel_q[1:0]] <= root_nx;
            3'd3: rms_q <= (root_nx > ROOT_W'(VIB_LIMIT)) ? VIB_W'(VIB_LIMIT)
                                                          : root_nx[VIB_W-1:0];
            default: peak_q <= (root_nx > ROOT_W'(VIB_LIMIT)) ? VIB_W'(VIB_LIMIT)
                                                              : root_nx[VIB_W-1:0];
          endcase
        end
      end
      ST_CI: begin
        // y of zero maps straight to 0 or 180 degrees
        if (cin_y == '0) begin
          m_q <= cin_x[CIN_W-1] ? ANG_W'(ANGLE_LIMIT) : '0;
        end else if (cin_x[CIN_W-1]) begin
          cx_q <= -cxs;
          cy_q <= -cys;
          cz_q <= cin_y[CIN_W-1] ? ZW'(-Z180) : ZW'(Z180);
        end else begin
          cx_q <= cxs;
          cy_q <= cys;
          cz_q <= '0;
        end
      end
      ST_CR: begin
        if (!cy_q[CW-1]) begin
          cx_q <= cx_q + c_dx;
          cy_q <= cy_q - c_dy;
          cz_q <= cz_q + c_at;
        end else begin
          cx_q <= cx_q - c_dx;
          cy_q <= cy_q + c_dy;
          cz_q <= cz_q - c_at;
        end
      end
      ST_CF: m_q <= z_clamp;
      ST_KS: begin
        p1_q   <= p1_c;
        den_q  <= den_c;
        drem_q <= DREM_W'(p1_c);
        k_q    <= '0;
        // First window seeds each filter with its measurement
        if (!started_q) begin
          est_q[sel_q[1:0]] <= m_q;
          cov_q[sel_q[1:0]] <= COV_W'(P_START);
          case (sel_q)
            3'd0:    pitch_q <= m_q;
            3'd1:    roll_q  <= m_q;
            default: total_q <= m_q;
          endcase
        end
      end
      ST_KD: begin
        drem_q <= d_ge ? (d_cur - DREM_W'(den_q)) : d_cur;
        k_q    <= {k_q[KW-2:0], d_ge};
      end
      ST_KX: begin
        est_q[sel_q[1:0]] <= x_new;
        case (sel_q)
          3'd0:    pitch_q <= x_new;
          3'd1:    roll_q  <= x_new;
          default: total_q <= x_new;
        endcase
      end
      ST_KP: cov_q[sel_q[1:0]] <= p_new;
      default: ;
    endcase
  end

  assign busy             = (state_q != ST_IDLE);
  assign valid_o          = valid_q;
  assign tilt_pitch_o     = pitch_q;
  assign tilt_roll_o      = roll_q;
  assign tilt_total_o     = total_q;
  assign vibration_rms_o  = rms_q;
  assign vibration_peak_o = peak_q;

endmodule

// File: rtl/tvwm_checker.sv
// Port-level checks for the tilt and vibration block, bound to its top level.
module tvwm_checker
  import tvwm_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     cfg_we_i,
  input logic [CFG_AW-1:0]        cfg_idx_i,
  input logic [CFG_DW-1:0]        cfg_data_i,
  input logic                     start,
  input logic                     busy,
  input logic signed [AXIS_W-1:0] accel_x_i,
  input logic signed [AXIS_W-1:0] accel_y_i,
  input logic signed [AXIS_W-1:0] accel_z_i,
  input logic                     valid_o,
  input logic signed [ANG_W-1:0]  tilt_pitch_o,
  input logic signed [ANG_W-1:0]  tilt_roll_o,
  input logic signed [ANG_W-1:0]  tilt_total_o,
  input logic [VIB_W-1:0]         vibration_rms_o,
  input logic [VIB_W-1:0]         vibration_peak_o
);

  // A result is a single-cycle strobe
  a_valid_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o) else $error("result strobe longer than one cycle");

  // A result ends a busy stretch
  a_valid_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (!busy && $past(busy))) else $error("result without end-of-window work");

  // Work only starts from an accepted transfer
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start)) else $error("busy without a transfer");

  // Filtered pitch and total angles stay within the clamp range
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (tilt_pitch_o <= ANG_W'(ANGLE_LIMIT) && tilt_pitch_o >= ANG_W'(-ANGLE_LIMIT)
              && tilt_total_o <= ANG_W'(ANGLE_LIMIT) && tilt_total_o >= ANG_W'(-ANGLE_LIMIT)))
    else $error("angle outside clamp range");

endmodule

bind tilt_vibration_window_metrics tvwm_checker u_tvwm_checker (.*);
